// ----- hdl/arma_iir_filter_macros.svh -----
// Assertion macros shared by the ARMA filter RTL
`ifndef ARMA_IIR_FILTER_MACROS_SVH
`define ARMA_IIR_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock outside reset
`define AIF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aif: same-cycle check failed");
// Next-cycle implication, checked on every clock outside reset
`define AIF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aif: next-cycle check failed");
`else
`define AIF_ASSERT_IMP(lbl, ante, cons)
`define AIF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/aif_pkg.sv -----
// Shared constants, types and codes of the ARMA filter
package aif_pkg;

    localparam int MA_TAPS_DEF     = 5;
    localparam int AR_TAPS_DEF     = 5;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 32;

    localparam int MODE_BITS      = 2;
    localparam int IDX_BITS       = 3;
    localparam int MANT_BITS      = 32;
    localparam int SHIFT_BITS     = 5;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [MANT_BITS-1:0]  MANT_RESET  = 32'h8000_0000;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = '0;

    // History words: signed, 8 fraction bits
    localparam int HIST_BITS  = 40;
    localparam int OUT_SHIFT  = 8;
    localparam int OUT_T_BITS = HIST_BITS - OUT_SHIFT;

    // Shared multiplier: 33-bit signed by 21-bit signed, history split at bit 20
    localparam int SPLIT_BITS = 20;
    localparam int MUL_A_BITS = 33;
    localparam int MUL_B_BITS = SPLIT_BITS + 1;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
    localparam int FULL_BITS  = MUL_A_BITS + HIST_BITS;

    localparam int Q_SHIFT     = 28;
    localparam int SCALE_BASE  = 23;
    localparam int SH_AMT_BITS = 6;
    localparam int TERM_BITS   = FULL_BITS - Q_SHIFT;
    localparam int ACC_GUARD   = 4;
    localparam int ACC_BITS    = TERM_BITS + ACC_GUARD;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_FILTER  = 2'd0,
        MODE_LOAD_MA = 2'd1,
        MODE_LOAD_AR = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SCALE_MANT  = 1'd0,
        CFG_SCALE_SHIFT = 1'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SUM,
        ST_SCALE_WB,
        ST_ACC_LAST,
        ST_SAT_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic mul_en;
        logic mul_hi;
        logic lo_load;
        logic acc_add;
        logic acc_clr;
        logic full_load;
        logic op_clr;
        logic op_inc;
        logic hist_wb;
        logic y_load;
        logic out_load;
    } ctrl_t;

endpackage

// ----- hdl/arma_iir_filter.sv -----
// Direct form I ARMA filter top level: sequencer, stores and shared multiplier
// Filter beat: m_tvalid and s_tready rise together once the result is loaded; no new
// sample is taken before that, and an untaken earlier result stalls the return to idle.
// The one shared multiplier sets the pace: two partial products and a combine per operation.
// Coefficient loads are written on acceptance; configuration writes are always ready.
// rst_n (async, active low) resets control and gain registers, coefficients, both histories.
`include "arma_iir_filter_macros.svh"

module arma_iir_filter
    import aif_pkg::*;
#(
    parameter int MA_TAPS     = MA_TAPS_DEF,
    parameter int AR_TAPS     = AR_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF,
    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + IDX_BITS + COEF_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,   // sample, coef_index, coef_value, pad
    input  logic [MODE_BITS-1:0]      s_tuser,   // mode
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,   // filtered, pad
    output logic                      m_tuser,   // saturated
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [MANT_BITS-1:0]      cfg_data
);

    // Operation 0 is the input scaling, 1..MA_TAPS the MA taps, then the AR taps
    localparam int LAST_OP     = MA_TAPS + AR_TAPS - 1;
    localparam int OP_BITS     = $clog2(LAST_OP + 1);
    localparam int AR_DEPTH    = (AR_TAPS > 1) ? AR_TAPS - 1 : 1;
    localparam int MA_IDX_BITS = (MA_TAPS > 1) ? $clog2(MA_TAPS) : 1;
    localparam int AR_IDX_BITS = (AR_DEPTH > 1) ? $clog2(AR_DEPTH) : 1;

    // ---------------------------------------------------------------------
    // Beat unpacking
    // ---------------------------------------------------------------------
    logic                         in_accept;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [IDX_BITS-1:0]          in_idx;
    logic signed [COEF_BITS-1:0]  in_coef;
    logic                         ma_wr;
    logic                         ar_wr;

    assign in_accept = s_tvalid && s_tready;
    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_idx    = s_tdata[SAMPLE_BITS +: IDX_BITS];
    assign in_coef   = s_tdata[SAMPLE_BITS + IDX_BITS +: COEF_BITS];

    // Out-of-range indexes drop the write; the zero-delay AR tap stays 0
    assign ma_wr = in_accept && (s_tuser == MODE_LOAD_MA)
                   && ({1'b0, in_idx} < (IDX_BITS + 1)'(MA_TAPS));
    assign ar_wr = in_accept && (s_tuser == MODE_LOAD_AR)
                   && ({1'b0, in_idx} < (IDX_BITS + 1)'(AR_TAPS - 1));

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    state_t                        state_reg;
    state_t                        state_next;
    ctrl_t                         ctrl;
    logic [OP_BITS-1:0]            op_reg;
    logic [MANT_BITS-1:0]          mant_reg;
    logic [SHIFT_BITS-1:0]         scale_shift_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [COEF_BITS-1:0]   ma_coef_reg [MA_TAPS];
    logic signed [COEF_BITS-1:0]   ar_coef_reg [AR_DEPTH];
    logic signed [HIST_BITS-1:0]   in_hist_reg [MA_TAPS];
    logic signed [HIST_BITS-1:0]   out_hist_reg [AR_DEPTH];
    logic signed [MUL_P_BITS-1:0]  lo_reg;
    logic signed [FULL_BITS-1:0]   full_reg;
    logic signed [FULL_BITS-1:0]   full_next;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [ACC_BITS-1:0]    acc_next;
    logic signed [HIST_BITS-1:0]   y_reg;
    logic signed [HIST_BITS-1:0]   y_next;
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_data_reg;
    logic                          out_flag_reg;

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == MODE_FILTER))
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                state_next = ST_MUL_SUM;
            end
            ST_MUL_SUM:
            begin
                if (op_reg == '0)
                begin
                    state_next = ST_SCALE_WB;
                end
                else if (op_reg == OP_BITS'(LAST_OP))
                begin
                    state_next = ST_ACC_LAST;
                end
                else
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_SCALE_WB:
            begin
                state_next = ST_MUL_LO;
            end
            ST_ACC_LAST:
            begin
                state_next = ST_SAT_WB;
            end
            ST_SAT_WB:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: control outputs
    // ---------------------------------------------------------------------
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.op_clr   = 1'b1;
            end
            ST_MUL_LO:
            begin
                ctrl.mul_en = 1'b1;
            end
            ST_MUL_HI:
            begin
                // Fold in the previous tap while the high half multiplies
                ctrl.mul_en  = 1'b1;
                ctrl.mul_hi  = 1'b1;
                ctrl.lo_load = 1'b1;
                ctrl.acc_add = ({1'b0, op_reg} >= (OP_BITS + 1)'(2));
            end
            ST_MUL_SUM:
            begin
                ctrl.full_load = 1'b1;
                ctrl.op_inc    = (op_reg != OP_BITS'(LAST_OP));
            end
            ST_SCALE_WB:
            begin
                ctrl.hist_wb = 1'b1;
                ctrl.acc_clr = 1'b1;
            end
            ST_ACC_LAST:
            begin
                ctrl.acc_add = 1'b1;
            end
            ST_SAT_WB:
            begin
                ctrl.y_load = 1'b1;
            end
            ST_DONE:
            begin
                ctrl.out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Operand selection for the shared multiplier
    // ---------------------------------------------------------------------
    logic [OP_BITS-1:0]           ma_sel;
    logic [OP_BITS-1:0]           ar_sel;
    logic                         op_is_ma;
    logic signed [HIST_BITS-1:0]  src_hist;
    logic signed [COEF_BITS-1:0]  src_coef;
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [MUL_P_BITS-1:0] mul_prod;

    assign ma_sel   = op_reg - OP_BITS'(1);
    assign ar_sel   = op_reg - OP_BITS'(MA_TAPS + 1);
    assign op_is_ma = (op_reg <= OP_BITS'(MA_TAPS));

    always_comb
    begin
        if (op_is_ma)
        begin
            src_hist = in_hist_reg[ma_sel[MA_IDX_BITS-1:0]];
            src_coef = ma_coef_reg[ma_sel[MA_IDX_BITS-1:0]];
        end
        else
        begin
            src_hist = out_hist_reg[ar_sel[AR_IDX_BITS-1:0]];
            src_coef = ar_coef_reg[ar_sel[AR_IDX_BITS-1:0]];
        end
        // Scaling: sample times unsigned mantissa
        if (op_reg == '0)
        begin
            src_hist = {{(HIST_BITS - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
            mul_a    = {1'b0, mant_reg};
        end
        else
        begin
            mul_a = {{(MUL_A_BITS - COEF_BITS){src_coef[COEF_BITS-1]}}, src_coef};
        end
        // Low half unsigned, high half signed
        if (ctrl.mul_hi)
        begin
            mul_b = {src_hist[HIST_BITS-1], src_hist[HIST_BITS-1:SPLIT_BITS]};
        end
        else
        begin
            mul_b = {1'b0, src_hist[SPLIT_BITS-1:0]};
        end
    end

    aif_mul u_mul
    (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // ---------------------------------------------------------------------
    // Combine halves, accumulate floor(product / 2^28), saturate
    // ---------------------------------------------------------------------
    logic signed [TERM_BITS-1:0]             term;
    logic [SH_AMT_BITS-1:0]                  scale_amt;
    logic signed [FULL_BITS-1:0]             scaled_full;
    logic [ACC_BITS-HIST_BITS:0]             acc_top;
    logic                                    acc_fits;
    logic signed [OUT_T_BITS-1:0]            out_t;
    logic [OUT_T_BITS-SAMPLE_BITS:0]         out_top;
    logic                                    out_fits;
    logic [SAMPLE_BITS-1:0]                  out_data_next;

    // The high product fits one bit below its register width
    assign full_next = {mul_prod[MUL_P_BITS-2:0], {SPLIT_BITS{1'b0}}}
                       + {{(FULL_BITS - MUL_P_BITS){lo_reg[MUL_P_BITS-1]}}, lo_reg};

    assign term      = full_reg[FULL_BITS-1:Q_SHIFT];
    assign acc_next  = acc_reg + {{ACC_GUARD{term[TERM_BITS-1]}}, term};

    assign scale_amt   = SH_AMT_BITS'(SCALE_BASE) + {1'b0, scale_shift_reg};
    assign scaled_full = full_reg >>> scale_amt;

    assign acc_top  = acc_reg[ACC_BITS-1:HIST_BITS-1];
    assign acc_fits = (&acc_top) || !(|acc_top);
    assign y_next   = acc_fits ? acc_reg[HIST_BITS-1:0]
                               : {acc_reg[ACC_BITS-1], {(HIST_BITS - 1){~acc_reg[ACC_BITS-1]}}};

    assign out_t    = y_reg[HIST_BITS-1:OUT_SHIFT];
    assign out_top  = out_t[OUT_T_BITS-1:SAMPLE_BITS-1];
    assign out_fits = (&out_top) || !(|out_top);
    assign out_data_next = out_fits ? out_t[SAMPLE_BITS-1:0]
                                    : {out_t[OUT_T_BITS-1],
                                       {(SAMPLE_BITS - 1){~out_t[OUT_T_BITS-1]}}};

    // ---------------------------------------------------------------------
    // Control registers, configuration, stores
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= '0;
            out_valid_reg   <= 1'b0;
            mant_reg        <= MANT_RESET;
            scale_shift_reg <= SHIFT_RESET;
            for (int i = 0; i < MA_TAPS; i++)
            begin
                ma_coef_reg[i] <= '0;
                in_hist_reg[i] <= '0;
            end
            for (int i = 0; i < AR_DEPTH; i++)
            begin
                ar_coef_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Operation counter
            if (ctrl.op_clr)
            begin
                op_reg <= '0;
            end
            else if (ctrl.op_inc)
            begin
                op_reg <= op_reg + OP_BITS'(1);
            end

            // Result register: hold until the beat is taken
            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_SCALE_MANT:  mant_reg        <= cfg_data;
                    CFG_SCALE_SHIFT: scale_shift_reg <= cfg_data[SHIFT_BITS-1:0];
                    default:         mant_reg        <= mant_reg;
                endcase
            end

            if (ma_wr)
            begin
                ma_coef_reg[in_idx[MA_IDX_BITS-1:0]] <= in_coef;
            end
            if (ar_wr)
            begin
                ar_coef_reg[in_idx[AR_IDX_BITS-1:0]] <= in_coef;
            end

            // Advance the input history with the scaled sample (wraps to 40 bits)
            if (ctrl.hist_wb)
            begin
                for (int i = 0; i < MA_TAPS - 1; i++)
                begin
                    in_hist_reg[i] <= in_hist_reg[i + 1];
                end
                in_hist_reg[MA_TAPS-1] <= scaled_full[HIST_BITS-1:0];
            end

            // Advance the output history with the saturated sum
            if (ctrl.y_load)
            begin
                for (int i = 0; i < AR_DEPTH - 1; i++)
                begin
                    out_hist_reg[i] <= out_hist_reg[i + 1];
                end
                out_hist_reg[AR_DEPTH-1] <= y_next;
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= in_sample;
        end
        if (ctrl.lo_load)
        begin
            lo_reg <= mul_prod;
        end
        if (ctrl.full_load)
        begin
            full_reg <= full_next;
        end
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.y_load)
        begin
            y_reg <= y_next;
        end
        if (ctrl.out_load)
        begin
            out_data_reg <= out_data_next;
            out_flag_reg <= !out_fits;
        end
    end

    // ---------------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------------
    assign s_tready  = ctrl.in_ready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_DATA_BITS'(out_data_reg);
    assign m_tuser   = out_flag_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    logic op_in_range;
    assign op_in_range = (op_reg <= OP_BITS'(LAST_OP));

    `AIF_ASSERT_NEXT(a_filter_starts, in_accept && (s_tuser == MODE_FILTER), state_reg == ST_MUL_LO)
    `AIF_ASSERT_IMP(a_op_in_range, state_reg != ST_IDLE, op_in_range)
    `AIF_ASSERT_NEXT(a_acc_cleared, state_reg == ST_SCALE_WB, acc_reg == '0)
    `AIF_ASSERT_NEXT(a_result_shown, ctrl.out_load, m_tvalid && (state_reg == ST_IDLE))

endmodule

// ----- hdl/aif_mul.sv -----
// Shared signed multiplier with registered product
module aif_mul
    import aif_pkg::*;
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [MUL_A_BITS-1:0] a,
    input  logic signed [MUL_B_BITS-1:0] b,
    output logic signed [MUL_P_BITS-1:0] prod
);

    logic signed [MUL_P_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- tb/arma_iir_filter_checker.sv -----
// Output predictor and result comparison for the ARMA filter testbench
module arma_iir_filter_checker
    import aif_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [63:0]               s_tdata,
    input  logic [MODE_BITS-1:0]      s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [23:0]               m_tdata,
    input  logic                      m_tuser,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [MANT_BITS-1:0]      cfg_data,
    output int                        fail_count,
    output int                        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MA_TAPS = MA_TAPS_DEF;
    localparam int AR_TAPS = AR_TAPS_DEF;
    localparam int SB      = SAMPLE_BITS_DEF;
    localparam int CB      = COEF_BITS_DEF;
    localparam int WIDE    = 80;

    localparam logic signed [WIDE-1:0] HIST_MAX = (80'sd1 <<< (HIST_BITS - 1)) - 80'sd1;
    localparam logic signed [WIDE-1:0] HIST_MIN = -HIST_MAX - 80'sd1;
    localparam logic signed [31:0]     OUT_MAX  = (32'sd1 <<< (SB - 1)) - 32'sd1;
    localparam logic signed [31:0]     OUT_MIN  = -OUT_MAX - 32'sd1;

    typedef struct packed {
        logic          saturated;
        logic [SB-1:0] filtered;
    } out_beat_t;

    logic [MANT_BITS-1:0]         gain_mant;
    logic [SHIFT_BITS-1:0]        gain_shift;
    logic signed [HIST_BITS-1:0]  in_hist  [MA_TAPS];
    logic signed [HIST_BITS-1:0]  out_hist [AR_TAPS-1];
    logic signed [CB-1:0]         ma_coef  [MA_TAPS];
    logic signed [CB-1:0]         ar_coef  [AR_TAPS-1];
    out_beat_t                    pending_outputs [$];

    // floor(coef * hist / 2^28), exact in the wide word
    function automatic logic signed [WIDE-1:0] q28_product(logic signed [CB-1:0] coef,
                                                          logic signed [HIST_BITS-1:0] hist);
        logic signed [WIDE-1:0] c;
        logic signed [WIDE-1:0] h;
        c = coef;
        h = hist;
        return (c * h) >>> Q_SHIFT;
    endfunction

    // Advance both histories by one sample and return the emitted beat
    function automatic out_beat_t filter_sample(logic signed [SB-1:0] x);
        logic signed [WIDE-1:0]               wide_x;
        logic signed [WIDE-1:0]               wide_m;
        logic signed [WIDE-1:0]               scaled;
        logic signed [WIDE-1:0]               acc;
        logic signed [HIST_BITS-1:0]          y;
        logic signed [31:0]                   y_out;
        out_beat_t                            beat;
        wide_x = x;
        wide_m = gain_mant;
        scaled = (wide_x * wide_m) >>> (SCALE_BASE + gain_shift);
        for (int i = 0; i < MA_TAPS - 1; i++)
            in_hist[i] = in_hist[i + 1];
        // wrap to the history width
        in_hist[MA_TAPS - 1] = scaled[HIST_BITS-1:0];

        acc = '0;
        for (int i = 0; i < MA_TAPS; i++)
            acc += q28_product(ma_coef[i], in_hist[i]);
        for (int i = 0; i < AR_TAPS - 1; i++)
            acc += q28_product(ar_coef[i], out_hist[i]);

        if (acc > HIST_MAX)
            y = HIST_MAX[HIST_BITS-1:0];
        else if (acc < HIST_MIN)
            y = HIST_MIN[HIST_BITS-1:0];
        else
            y = acc[HIST_BITS-1:0];
        for (int i = 0; i < AR_TAPS - 2; i++)
            out_hist[i] = out_hist[i + 1];
        out_hist[AR_TAPS - 2] = y;

        y_out = y >>> OUT_SHIFT;
        beat.saturated = 1'b1;
        if (y_out > OUT_MAX)
            beat.filtered = OUT_MAX[SB-1:0];
        else if (y_out < OUT_MIN)
            beat.filtered = OUT_MIN[SB-1:0];
        else
        begin
            beat.filtered  = y_out[SB-1:0];
            beat.saturated = 1'b0;
        end
        return beat;
    endfunction

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [IDX_BITS-1:0] idx;
        logic [CB-1:0]       coef;
        out_beat_t           want;
        if (!rst_n)
        begin
            gain_mant  = MANT_RESET;
            gain_shift = SHIFT_RESET;
            for (int i = 0; i < MA_TAPS; i++)
            begin
                in_hist[i] = '0;
                ma_coef[i] = '0;
            end
            for (int i = 0; i < AR_TAPS - 1; i++)
            begin
                out_hist[i] = '0;
                ar_coef[i]  = '0;
            end
            pending_outputs.delete();
            pending_count <= 0;
        end
        else
        begin
            // Compare first: a beat leaving now belongs to an older sample
            if (m_tvalid && m_tready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: filtered %0d saturated %0b",
                             $time, $signed(m_tdata[SB-1:0]), m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (m_tdata[SB-1:0] !== want.filtered)
                    begin
                        $display("%0t: filtered mismatch: expected %0d, got %0d", $time,
                                 $signed(want.filtered), $signed(m_tdata[SB-1:0]));
                        fail_count++;
                    end
                    if (m_tuser !== want.saturated)
                    begin
                        $display("%0t: saturated flag mismatch: expected %0b, got %0b", $time,
                                 want.saturated, m_tuser);
                        fail_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SCALE_MANT)
                    gain_mant = cfg_data;
                else if (cfg_index == CFG_SCALE_SHIFT)
                    gain_shift = cfg_data[SHIFT_BITS-1:0];
            end

            if (s_tvalid && s_tready)
            begin
                idx  = s_tdata[SB +: IDX_BITS];
                coef = s_tdata[SB + IDX_BITS +: CB];
                case (s_tuser)
                    MODE_FILTER:  pending_outputs.push_back(filter_sample(s_tdata[SB-1:0]));
                    MODE_LOAD_MA: if (idx < MA_TAPS) ma_coef[idx] = coef;
                    MODE_LOAD_AR: if (idx < AR_TAPS - 1) ar_coef[idx] = coef;
                    default:      ;
                endcase
            end
            pending_count <= pending_outputs.size();
        end
    end

endmodule

// ----- tb/arma_iir_filter_test.sv -----
// Stimulus, flow control and verdict for the ARMA filter testbench
module arma_iir_filter_test;
    import aif_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB     = SAMPLE_BITS_DEF;
    localparam int CB     = COEF_BITS_DEF;
    localparam int IN_W   = ((SB + IDX_BITS + CB + 7) / 8) * 8;
    localparam int OUT_W  = ((SB + 7) / 8) * 8;
    // Settling wait after the last result, scaled with the tap counts
    localparam int DRAIN_CYCLES = 3 * (MA_TAPS_DEF + AR_TAPS_DEF) + 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    // Coefficient spreads: MA within +/-1.0, AR within +/-0.25 (Q4.28)
    localparam logic [31:0] MA_SPAN = 32'h2000_0000;
    localparam logic [31:0] AR_SPAN = 32'h0800_0000;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_W-1:0]           s_tdata   = '0;
    logic [MODE_BITS-1:0]      s_tuser   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_W-1:0]          m_tdata;
    logic                      m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [MANT_BITS-1:0]      cfg_data  = '0;

    int          fail_count;
    int          pending;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_request   = 1'b0;
    logic        hold_taken     = 1'b0;
    int          hold_left      = 0;
    int          cycle_count    = 0;

    arma_iir_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arma_iir_filter_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: end the run if it never drains
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("arma_iir_filter verification failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when requested so the
    // filter backs up and drops s_tready while the sender keeps offering beats
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_taken)
        begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Mostly a small coefficient around zero; now and then any value or an extreme
    function automatic logic [CB-1:0] pick_coef(logic [31:0] span);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return $urandom_range(span) - (span >> 1);
        else if (roll < 95)
            return $urandom;
        else
            return roll[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // Offer one beat, idling first at random; return once it is accepted
    task automatic push_item(logic [MODE_BITS-1:0] mode_code, logic [SB-1:0] smp,
                             logic [IDX_BITS-1:0] idx, logic [CB-1:0] coef);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode_code;
        s_tdata  <= IN_W'({coef, idx, smp});   // sample, coef_index, coef_value, pad
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold the input until every result is out and the sequencer is surely idle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Keep cfg_valid high across back-to-back writes; the caller drops it
    task automatic write_reg(cfg_reg_t reg_sel, logic [MANT_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_gain(logic [MANT_BITS-1:0] mant, logic [MANT_BITS-1:0] shift_word);
        write_reg(CFG_SCALE_MANT, mant);
        write_reg(CFG_SCALE_SHIFT, shift_word);
        cfg_valid <= 1'b0;
    endtask

    // Full, well-formed coefficient set: every MA tap and every usable AR tap
    task automatic load_coef_set();
        for (int i = 0; i < MA_TAPS_DEF; i++)
            push_item(MODE_LOAD_MA, SB'($urandom), IDX_BITS'(i), pick_coef(MA_SPAN));
        for (int i = 0; i < AR_TAPS_DEF - 1; i++)
            push_item(MODE_LOAD_AR, SB'($urandom), IDX_BITS'(i), pick_coef(AR_SPAN));
    endtask

    // Mostly samples, some stray coefficient loads (any index) and unused-mode beats
    task automatic push_random_item();
        int unsigned       roll;
        logic [31:0]       r;
        logic [SB-1:0]     smp;
        logic [IDX_BITS-1:0] idx;
        roll = $urandom_range(99);
        r    = $urandom;
        smp  = roll[0] ? r[SB-1:0] : {{(SB - 16){r[15]}}, r[15:0]};
        idx  = IDX_BITS'($urandom_range(7));
        if (roll < 84)
            push_item(MODE_FILTER, smp, idx, $urandom);
        else if (roll < 91)
            push_item(MODE_LOAD_MA, smp, idx, pick_coef(MA_SPAN));
        else if (roll < 97)
            push_item(MODE_LOAD_AR, smp, idx, pick_coef(AR_SPAN));
        else
            push_item(MODE_UNUSED, smp, idx, $urandom);
    endtask

    task automatic run_phase(logic [MANT_BITS-1:0] mant, logic [MANT_BITS-1:0] shift_word,
                             int unsigned send_pct, int unsigned recv_pct, int count);
        drain();
        set_gain(mant, shift_word);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        load_coef_set();
        repeat (count) push_random_item();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset gain (1.0, no extra shift), no idling.
        // Zero coefficients first: output must be zero for full-scale input.
        push_item(MODE_FILTER,  24'h00_0000, 3'd0, 32'h0000_0000);
        push_item(MODE_FILTER,  24'h7F_FFFF, 3'd7, 32'hFFFF_FFFF);
        // Newest MA tap = 1.0 gives a straight pass-through
        push_item(MODE_LOAD_MA, 24'h00_0000, 3'd4, 32'h1000_0000);
        push_item(MODE_FILTER,  24'h80_0000, 3'd0, 32'h0000_0000);
        push_item(MODE_FILTER,  24'h7F_FFFF, 3'd0, 32'h0000_0000);
        // MA index past the taps, AR zero-delay tap and AR index past the taps:
        // all dropped, as is the unused mode
        push_item(MODE_LOAD_MA, 24'h00_0000, 3'd7, 32'hFFFF_FFFF);
        push_item(MODE_LOAD_AR, 24'h00_0000, 3'd4, 32'h7FFF_FFFF);
        push_item(MODE_LOAD_AR, 24'h00_0000, 3'd7, 32'h8000_0000);
        push_item(MODE_UNUSED,  24'hFF_FFFF, 3'd7, 32'hFFFF_FFFF);
        push_item(MODE_FILTER,  24'h00_0001, 3'd0, 32'h0000_0000);
        // Largest AR feedback on the newest output: drives the output into clipping
        push_item(MODE_LOAD_AR, 24'h00_0000, 3'd3, 32'h7FFF_FFFF);
        push_item(MODE_FILTER,  24'h7F_FFFF, 3'd0, 32'h0000_0000);
        push_item(MODE_FILTER,  24'h7F_FFFF, 3'd0, 32'h0000_0000);
        push_item(MODE_FILTER,  24'h80_0000, 3'd0, 32'h0000_0000);
        // Most negative coefficients on the oldest taps: accumulator hits the rails
        push_item(MODE_LOAD_MA, 24'h00_0000, 3'd0, 32'h8000_0000);
        push_item(MODE_LOAD_AR, 24'h00_0000, 3'd0, 32'h8000_0000);
        push_item(MODE_FILTER,  24'hFF_FFFF, 3'd0, 32'h0000_0000);
        push_item(MODE_FILTER,  24'h80_0000, 3'd0, 32'h0000_0000);
        push_item(MODE_FILTER,  24'h00_0000, 3'd0, 32'h0000_0000);
        push_item(MODE_FILTER,  24'h7F_FFFF, 3'd0, 32'h0000_0000);

        // Random phases, each under its own gain and flow-control pattern
        run_phase(32'h8000_0000, 32'd0, 0, 0, 150);
        run_phase(32'hFFFF_FFFF, 32'd0, 85, 0, 150);
        // Upper data bits of the shift write are don't-care
        run_phase($urandom, (32'($urandom) & 32'hFFFF_FFE0) | 32'd31, 0, 85, 150);
        run_phase($urandom, 32'($urandom_range(4)), 25, 25, 150);
        run_phase(32'h0000_0000, 32'd0, 0, 0, 60);
        run_phase(32'h4000_0000, 32'd1, 25, 25, 150);

        // Back-pressure: hold the result side off while offering samples flat out
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request  <= 1'b1;
        repeat (24) push_random_item();

        drain();
        if (fail_count == 0 && pending == 0)
            $display("arma_iir_filter verification clean");
        else
            $display("arma_iir_filter verification failed");
        $finish;
    end

endmodule

// ----- arma_iir_filter.f -----
+incdir+hdl
hdl/aif_pkg.sv
hdl/aif_mul.sv
hdl/arma_iir_filter.sv
tb/arma_iir_filter_checker.sv
tb/arma_iir_filter_test.sv
